/* sv/save_region_check_and_pick_defines.svh */
// assertion macros for the save region checker
// used by save_region_check_and_pick.sv; expects clk and rst in scope
`ifndef SAVE_REGION_CHECK_AND_PICK_DEFINES_SVH
`define SAVE_REGION_CHECK_AND_PICK_DEFINES_SVH

// property checked at every rising edge outside reset
`define SRCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the cycle after the trigger, outside reset
`define SRCP_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

/* sv/srcp_pkg.sv */
// shared constants and types for the save region checker
// no dependencies; imported by save_region_check_and_pick
package srcp_pkg;

  localparam int REGION_WORDS = 1248;
  localparam int REGIONS      = 6;
  localparam int SLOTS        = 4;

  localparam int POS_W  = $clog2(REGION_WORDS);
  localparam int RC_W   = $clog2(REGIONS + 1);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // word positions inside a record
  localparam int POS_CHECK_A = 12;
  localparam int POS_CHECK_B = 13;
  localparam int POS_SLOT    = 14;
  localparam int POS_COUNT   = 15;

  // magic text, big-endian words; last word compares upper three bytes
  localparam logic [31:0] MAGIC_W0      = 32'h4D61_7269;
  localparam logic [31:0] MAGIC_W1      = 32'h6F20_5374;
  localparam logic [31:0] MAGIC_W2      = 32'h6F72_7920;
  localparam logic [31:0] MAGIC_W3      = 32'h3030_3600;
  localparam logic [31:0] MAGIC_W3_MASK = 32'hFFFF_FF00;

  typedef enum logic [1:0] {
    CMD_WORD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    FAIL_OK      = 3'd0,
    FAIL_MAGIC   = 3'd1,
    FAIL_CHECK   = 3'd2,
    FAIL_SUM     = 3'd3,
    FAIL_SLOT    = 3'd4
  } fail_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // result beat payload, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] newest_count;
    logic [2:0]  newest_record;
    logic        newest_present;
    logic        became_newest;
    logic [31:0] count_word;
    logic [31:0] slot_word;
    logic [2:0]  fail_reason;
    logic [2:0]  record_index;
  } result_t;

endpackage

/* sv/save_region_check_and_pick.sv */
// save region checker and newest-record picker, top level
// depends on srcp_pkg and save_region_check_and_pick_defines.svh
//
// Usage:
//   s_* channel carries one command beat: tuser holds cmd (record word,
//   restart, query), tdata holds the record word and the queried slot.
//   Record words stream in order, REGION_WORDS per record, up to REGIONS
//   records; later words are dropped until a restart.
//   m_* channel carries one result beat at the last word of each record
//   (tuser = 0, report) and for each query (tuser = 1, slot answer).
//   A result appears on m_* in the cycle after the beat that causes it.
//   Throughput: one beat per cycle while not stalled; all checking for a
//   beat is done in the cycle it is accepted, with the slot table and running
//   sum held in registers and the result captured in one output register.
//   Restart gives no result; it clears the slot table and record counter.
//   Reset: record state cleared, slot table empty, no result pending.
//   Stall: while m_tready is low and a result is pending, s_tready drops,
//   so no beat is taken and nothing is lost; s_tready is high otherwise and
//   follows m_tready combinationally while a result is pending.
`include "save_region_check_and_pick_defines.svh"

module save_region_check_and_pick (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // word [31:0], query_slot [33:32], zero pad
  input  logic [1:0]   s_tuser,   // cmd [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // record_index, fail_reason, slot_word, count_word,
                                  // became_newest, newest_present, newest_record,
                                  // newest_count, zero pad
  output logic [0:0]   m_tuser    // kind [0]
);
  import srcp_pkg::*;

  // per-record state
  logic [POS_W-1:0] word_position, word_position_next;
  logic [RC_W-1:0]  record_counter, record_counter_next;
  logic [31:0]      running_sum, running_sum_next;
  logic             magic_matched, magic_matched_next;
  logic [31:0]      check_a, check_a_next;
  logic [31:0]      check_b, check_b_next;
  logic [31:0]      held_slot, held_slot_next;
  logic [31:0]      held_count, held_count_next;

  // slot table
  logic [SLOTS-1:0] slot_valid;
  logic [31:0]      slot_best_count  [SLOTS];
  logic [2:0]       slot_best_record [SLOTS];

  result_t          out_data;
  logic             out_valid;
  logic             out_kind;

  logic             accept;
  cmd_t             cmd;
  logic [31:0]      in_word;
  logic [31:0]      query_ext;
  logic             word_beat;
  logic             last_word;
  logic             magic_bad;
  logic [31:0]      rd_slot;
  logic [SLOT_W-1:0] rd_idx;
  logic             rd_in_range;
  logic             entry_valid;
  logic [31:0]      entry_count;
  logic [2:0]       entry_record;
  fail_t            reason;
  logic             take_new;
  logic             produce;
  logic [31:0]      rec_ext;
  result_t          res;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign in_word  = s_tdata[31:0];
  assign query_ext = {30'd0, s_tdata[33:32]};
  assign rec_ext  = 32'(record_counter);

  assign word_beat = accept && (cmd == CMD_WORD) && (32'(record_counter) < 32'(REGIONS));
  assign last_word = (word_position == POS_W'(REGION_WORDS - 1));

  // magic text check on the first four words
  always_comb begin
    magic_bad = 1'b0;
    if (word_position == POS_W'(0)) magic_bad = (in_word != MAGIC_W0);
    if (word_position == POS_W'(1)) magic_bad = (in_word != MAGIC_W1);
    if (word_position == POS_W'(2)) magic_bad = (in_word != MAGIC_W2);
    if (word_position == POS_W'(3)) magic_bad = ((in_word & MAGIC_W3_MASK) != MAGIC_W3);
  end

  // record state next values, capture fields on this beat
  always_comb begin
    running_sum_next   = running_sum + in_word;
    magic_matched_next = magic_matched && !magic_bad;
    check_a_next    = (word_position == POS_W'(POS_CHECK_A)) ? in_word : check_a;
    check_b_next    = (word_position == POS_W'(POS_CHECK_B)) ? in_word : check_b;
    held_slot_next  = (word_position == POS_W'(POS_SLOT))    ? in_word : held_slot;
    held_count_next = (word_position == POS_W'(POS_COUNT))   ? in_word : held_count;
    word_position_next  = word_position + POS_W'(1);
    record_counter_next = record_counter + RC_W'(1);
  end

  // one table read: queried slot or the record's slot
  assign rd_slot     = (cmd == CMD_QUERY) ? query_ext : held_slot_next;
  assign rd_in_range = rd_slot < 32'(SLOTS);
  assign rd_idx      = rd_slot[SLOT_W-1:0];
  assign entry_valid  = rd_in_range && slot_valid[rd_idx];
  assign entry_count  = slot_best_count[rd_idx];
  assign entry_record = slot_best_record[rd_idx];

  // failure reason in priority order
  always_comb begin
    if (!magic_matched_next) begin
      reason = FAIL_MAGIC;
    end else if (check_a_next != ~check_b_next) begin
      reason = FAIL_CHECK;
    end else if (running_sum_next != check_a_next) begin
      reason = FAIL_SUM;
    end else if (!rd_in_range) begin
      reason = FAIL_SLOT;
    end else begin
      reason = FAIL_OK;
    end
  end

  assign take_new = word_beat && last_word && (reason == FAIL_OK) &&
                    (!entry_valid || ($signed(held_count_next) > $signed(entry_count)));
  assign produce  = (accept && (cmd == CMD_QUERY)) || (word_beat && last_word);

  // result beat contents
  always_comb begin
    res = '0;
    if (cmd == CMD_QUERY) begin
      res.slot_word = query_ext;
      if (entry_valid) begin
        res.newest_present = 1'b1;
        res.newest_record  = entry_record;
        res.newest_count   = entry_count;
      end
    end else begin
      res.record_index  = rec_ext[2:0];
      res.fail_reason   = reason;
      res.slot_word     = held_slot_next;
      res.count_word    = held_count_next;
      res.became_newest = take_new;
      if (take_new) begin
        res.newest_present = 1'b1;
        res.newest_record  = rec_ext[2:0];
        res.newest_count   = held_count_next;
      end else if (entry_valid) begin
        res.newest_present = 1'b1;
        res.newest_record  = entry_record;
        res.newest_count   = entry_count;
      end
    end
  end

  // record state and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position  <= '0;
      record_counter <= '0;
      running_sum    <= '0;
      magic_matched  <= 1'b1;
      check_a        <= '0;
      check_b        <= '0;
      held_slot      <= '0;
      held_count     <= '0;
      slot_valid     <= '0;
    end else if (accept && (cmd == CMD_RESTART)) begin
      word_position  <= '0;
      record_counter <= '0;
      running_sum    <= '0;
      magic_matched  <= 1'b1;
      check_a        <= '0;
      check_b        <= '0;
      held_slot      <= '0;
      held_count     <= '0;
      slot_valid     <= '0;
    end else if (word_beat) begin
      if (last_word) begin
        word_position  <= '0;
        record_counter <= record_counter_next;
        running_sum    <= '0;
        magic_matched  <= 1'b1;
        check_a        <= '0;
        check_b        <= '0;
        held_slot      <= '0;
        held_count     <= '0;
        if (take_new) begin
          slot_valid[rd_idx] <= 1'b1;
        end
      end else begin
        word_position <= word_position_next;
        running_sum   <= running_sum_next;
        magic_matched <= magic_matched_next;
        check_a       <= check_a_next;
        check_b       <= check_b_next;
        held_slot     <= held_slot_next;
        held_count    <= held_count_next;
      end
    end
  end

  // slot table payload
  always_ff @(posedge clk) begin
    if (take_new) begin
      slot_best_count[rd_idx]  <= held_count_next;
      slot_best_record[rd_idx] <= rec_ext[2:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_data <= res;
      out_kind <= (cmd == CMD_QUERY) ? KIND_QUERY : KIND_REPORT;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;
  assign m_tuser[0] = out_kind;

  `SRCP_ASSERT(a_pos_range, 32'(word_position) < 32'(REGION_WORDS),
               "word position past end of record")
  `SRCP_ASSERT(a_rec_range, 32'(record_counter) <= 32'(REGIONS),
               "record counter past record limit")
  `SRCP_ASSERT(a_newest_ok,
               !(out_valid && (out_kind == KIND_REPORT) && out_data.became_newest) ||
               ((out_data.fail_reason == FAIL_OK) && out_data.newest_present),
               "newest record taken from a failed record")
  `SRCP_ASSERT_NEXT(a_query_answer, accept && (cmd == CMD_QUERY),
                    out_valid && (out_kind == KIND_QUERY),
                    "query gave no answer beat")
  `SRCP_ASSERT_NEXT(a_restart_clear, accept && (cmd == CMD_RESTART),
                    (slot_valid == '0) && (record_counter == '0),
                    "restart left slot table or counter set")

endmodule

/* test/tb_save_region_check_and_pick.sv */
// testbench for save_region_check_and_pick: streams save records and commands,
// predicts every report and query answer, and checks them field by field
// depends on srcp_pkg and the save_region_check_and_pick top level
`timescale 1ns / 100ps

module tb_save_region_check_and_pick;
  import srcp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int MIN_REPORTS = 48;
  localparam int LAST_POS    = REGION_WORDS - 1;

  typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_CHECK, FLAW_SUM} flaw_t;

  typedef struct {
    logic    kind;
    result_t body;
  } awaited_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata  = '0;   // word [31:0], query_slot [33:32], zero pad
  logic [1:0]   s_tuser  = CMD_WORD;   // cmd [1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;   // record_index, fail_reason, slot_word, count_word, became_newest,
                           // newest_present, newest_record, newest_count, zero pad
  logic [0:0]   m_tuser;   // kind [0]

  save_region_check_and_pick dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // expected scanner state
  int          scan_pos;
  int          scan_rec;
  logic [31:0] scan_sum;
  logic        scan_magic_ok;
  logic [31:0] scan_chk_a;
  logic [31:0] scan_chk_b;
  logic [31:0] scan_slot;
  logic [31:0] scan_count;
  logic        slot_ok  [SLOTS];
  logic [31:0] slot_cnt [SLOTS];
  logic [2:0]  slot_rec [SLOTS];

  awaited_t    awaited_reports[$];
  int          reports_due;
  int          mismatches;
  int          stalled_cycles;
  int          ready_hold;
  bit          steady;
  logic [31:0] image [REGION_WORDS];

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // per-record checking state back to its start
  function automatic void clear_record();
    scan_pos      = 0;
    scan_sum      = '0;
    scan_magic_ok = 1'b1;
    scan_chk_a    = '0;
    scan_chk_b    = '0;
    scan_slot     = '0;
    scan_count    = '0;
  endfunction

  function automatic void clear_image_state();
    clear_record();
    scan_rec = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_ok[i]  = 1'b0;
      slot_cnt[i] = '0;
      slot_rec[i] = '0;
    end
  endfunction

  // append one expected result beat at the tail of the queue
  function automatic void add_awaited(awaited_t a);
    awaited_reports = {awaited_reports, a};
  endfunction

  // slot table entry for the slot concerned, zero when out of range or empty
  function automatic result_t with_newest(result_t r, logic [31:0] s);
    if (s < SLOTS && slot_ok[s]) begin
      r.newest_present = 1'b1;
      r.newest_record  = slot_rec[s];
      r.newest_count   = slot_cnt[s];
    end
    return r;
  endfunction

  // expected effect of one accepted command beat
  function automatic void scan_save_beat(logic [1:0] c, logic [31:0] w, logic [1:0] q);
    awaited_t a;
    fail_t    why;
    logic     took;
    a = '{kind: KIND_REPORT, body: '0};
    case (c)
      CMD_RESTART: clear_image_state();
      CMD_QUERY: begin
        a.kind = KIND_QUERY;
        a.body.slot_word = 32'(q);
        a.body = with_newest(a.body, 32'(q));
        add_awaited(a);
      end
      CMD_WORD: begin
        if (scan_rec < REGIONS) begin
          scan_sum = scan_sum + w;
          if ((scan_pos == 0 && w != MAGIC_W0) || (scan_pos == 1 && w != MAGIC_W1) ||
              (scan_pos == 2 && w != MAGIC_W2) ||
              (scan_pos == 3 && (w & MAGIC_W3_MASK) != MAGIC_W3))
            scan_magic_ok = 1'b0;
          if (scan_pos == POS_CHECK_A) scan_chk_a = w;
          if (scan_pos == POS_CHECK_B) scan_chk_b = w;
          if (scan_pos == POS_SLOT)    scan_slot  = w;
          if (scan_pos == POS_COUNT)   scan_count = w;
          if (scan_pos < LAST_POS) begin
            scan_pos++;
          end else begin
            // end of record: first failure wins
            if (!scan_magic_ok)              why = FAIL_MAGIC;
            else if (scan_chk_a != ~scan_chk_b) why = FAIL_CHECK;
            else if (scan_sum != scan_chk_a)  why = FAIL_SUM;
            else if (scan_slot >= SLOTS)      why = FAIL_SLOT;
            else                              why = FAIL_OK;
            took = 1'b0;
            if (why == FAIL_OK && (!slot_ok[scan_slot] ||
                $signed(scan_count) > $signed(slot_cnt[scan_slot]))) begin
              slot_ok[scan_slot]  = 1'b1;
              slot_cnt[scan_slot] = scan_count;
              slot_rec[scan_slot] = 3'(scan_rec);
              took = 1'b1;
            end
            a.body.record_index  = 3'(scan_rec);
            a.body.fail_reason   = why;
            a.body.slot_word     = scan_slot;
            a.body.count_word    = scan_count;
            a.body.became_newest = took;
            a.body = with_newest(a.body, scan_slot);
            add_awaited(a);
            reports_due++;
            scan_rec++;
            clear_record();
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic match_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_result();
    awaited_t want;
    result_t  got;
    got = result_t'(m_tdata);
    if (awaited_reports.size() == 0) begin
      log_mismatch($sformatf("result beat with nothing expected, kind %0d", m_tuser));
      return;
    end
    want = awaited_reports.pop_front();
    match_field("kind", 32'(m_tuser), 32'(want.kind));
    match_field("record_index", 32'(got.record_index), 32'(want.body.record_index));
    match_field("fail_reason", 32'(got.fail_reason), 32'(want.body.fail_reason));
    match_field("slot_word", got.slot_word, want.body.slot_word);
    match_field("count_word", got.count_word, want.body.count_word);
    match_field("became_newest", 32'(got.became_newest), 32'(want.body.became_newest));
    match_field("newest_present", 32'(got.newest_present), 32'(want.body.newest_present));
    match_field("newest_record", 32'(got.newest_record), 32'(want.body.newest_record));
    match_field("newest_count", got.newest_count, want.body.newest_count);
  endtask

  // sample both channels, predict, check, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) scan_save_beat(s_tuser, s_tdata[31:0], s_tdata[33:32]);
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles == STALL_LIMIT) begin
          $display("save_region_check_and_pick verification failed");
          $finish;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_tready <= 1'b1;
      ready_hold = pick_idle();
    end
  end

  // drive one command beat and wait until it is taken
  task automatic send_beat(input logic [1:0] c, input logic [31:0] w, input logic [1:0] q);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, q, w};
    s_tuser  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // well-formed record with one optional flaw; the last word balances the sum
  task automatic build_record(input flaw_t flaw, input logic [31:0] slot,
                              input logic [31:0] cnt);
    logic [31:0] acc;
    logic [31:0] pair;
    logic [31:0] nz;
    int          k;
    image[0] = MAGIC_W0;
    image[1] = MAGIC_W1;
    image[2] = MAGIC_W2;
    image[3] = MAGIC_W3 | 32'($urandom_range(0, 255));
    for (k = 4; k < REGION_WORDS; k++) image[k] = $urandom;
    pair = $urandom;
    image[POS_CHECK_A] = pair;
    image[POS_CHECK_B] = ~pair;
    image[POS_SLOT]    = slot;
    image[POS_COUNT]   = cnt;
    acc = '0;
    for (k = 0; k < LAST_POS; k++) acc = acc + image[k];
    image[LAST_POS] = pair - acc;
    nz = $urandom;
    if (nz == 0) nz = 32'h1;
    case (flaw)
      FLAW_MAGIC: begin
        k = $urandom_range(0, 3);
        image[k] = image[k] ^ (32'h1 << $urandom_range((k == 3) ? 8 : 0, 31));
      end
      FLAW_CHECK: image[POS_CHECK_B] = image[POS_CHECK_B] ^ nz;
      FLAW_SUM:   image[LAST_POS] = image[LAST_POS] + nz;
      default: ;
    endcase
  endtask

  // stream the first len words, with the odd query or unused command mixed in when chatter is set
  task automatic stream_record(input int len, input bit chatter);
    for (int k = 0; k < len; k++) begin
      if (chatter && $urandom_range(0, 299) == 0)
        send_beat(CMD_QUERY, $urandom, 2'($urandom));
      if (chatter && $urandom_range(0, 599) == 0)
        send_beat(CMD_UNUSED, $urandom, 2'($urandom));
      send_beat(CMD_WORD, image[k], 2'($urandom));
    end
  endtask

  task automatic send_record(input flaw_t flaw, input logic [31:0] slot,
                             input logic [31:0] cnt);
    build_record(flaw, slot, cnt);
    stream_record(REGION_WORDS, 1'b0);
  endtask

  task automatic query_all();
    for (int s = 0; s < 4; s++) send_beat(CMD_QUERY, $urandom, 2'(s));
  endtask

  // fresh table answers empty; unused command does nothing
  task automatic test_empty_table();
    steady = 1'b1;
    query_all();
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 2'd3);
    send_beat(CMD_QUERY, 32'h0, 2'd0);
    steady = 1'b0;
  endtask

  // each failure reason, failed reports showing the table, records past the limit
  task automatic test_failure_reasons();
    send_beat(CMD_RESTART, 32'h0, 2'd0);
    send_record(FLAW_NONE, 32'd0, 32'd5);
    send_record(FLAW_MAGIC, 32'd0, 32'd9);
    send_record(FLAW_CHECK, 32'd0, 32'd9);
    send_record(FLAW_SUM, 32'd0, 32'd9);
    send_record(FLAW_NONE, 32'd4, 32'd1);
    send_record(FLAW_NONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_record(FLAW_NONE, 32'd1, 32'd1);
    query_all();
  endtask

  // signed count ordering, ties and the extremes of the count word
  task automatic test_newest_pick();
    send_beat(CMD_RESTART, 32'hFFFF_FFFF, 2'd3);
    send_record(FLAW_NONE, 32'd1, 32'h8000_0000);
    send_record(FLAW_NONE, 32'd1, 32'h8000_0000);
    send_record(FLAW_NONE, 32'd1, 32'h7FFF_FFFF);
    send_record(FLAW_NONE, 32'd1, 32'hFFFF_FFFF);
    send_record(FLAW_NONE, 32'd3, 32'h0);
    send_record(FLAW_NONE, 32'd2, 32'd9);
    query_all();
    send_beat(CMD_RESTART, 32'h0, 2'd0);
    query_all();
  endtask

  // restart in the middle of a record discards it
  task automatic test_restart_midway();
    build_record(FLAW_NONE, 32'd2, 32'd3);
    stream_record(REGION_WORDS / 2, 1'b0);
    send_beat(CMD_RESTART, 32'h0, 2'd0);
    send_record(FLAW_NONE, 32'd0, 32'd7);
    send_beat(CMD_QUERY, 32'h0, 2'd0);
    send_beat(CMD_QUERY, 32'h0, 2'd2);
  endtask

  // random images: mostly good records, some flawed, some cut off by a restart
  task automatic test_random_images();
    int          n_rec;
    int          r;
    logic [31:0] slot;
    logic [31:0] cnt;
    flaw_t       flaw;
    while (reports_due < MIN_REPORTS) begin
      steady = ($urandom_range(0, 3) == 0);
      send_beat(CMD_RESTART, $urandom, 2'($urandom));
      n_rec = $urandom_range(1, REGIONS + 2);
      for (int k = 0; k < n_rec; k++) begin
        r = $urandom_range(0, 99);
        slot = (r < 80) ? 32'($urandom_range(0, 3)) : $urandom;
        r = $urandom_range(0, 99);
        if (r < 60)      cnt = 32'($urandom_range(0, 6)) - 32'd3;
        else if (r < 70) cnt = 32'h8000_0000;
        else if (r < 80) cnt = 32'h7FFF_FFFF;
        else             cnt = $urandom;
        r = $urandom_range(0, 99);
        if (r < 64)      flaw = FLAW_NONE;
        else if (r < 73) flaw = FLAW_MAGIC;
        else if (r < 82) flaw = FLAW_CHECK;
        else             flaw = FLAW_SUM;
        build_record(flaw, slot, cnt);
        if ($urandom_range(0, 24) == 0) begin
          stream_record($urandom_range(1, LAST_POS), 1'b1);
          break;
        end
        stream_record(REGION_WORDS, 1'b1);
      end
      query_all();
    end
    steady = 1'b0;
  endtask

  initial begin
    mismatches     = 0;
    reports_due    = 0;
    stalled_cycles = 0;
    ready_hold     = 0;
    steady         = 1'b0;
    clear_image_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_failure_reasons();
    test_newest_pick();
    test_restart_midway();
    test_random_images();

    // drain outstanding results, then idle to catch strays
    s_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0)
      $display("save_region_check_and_pick verification clean");
    else
      $display("save_region_check_and_pick verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/srcp_pkg.sv
sv/save_region_check_and_pick.sv
test/tb_save_region_check_and_pick.sv
